### hw/rtl/tksi_pkg.sv
// Shared constants, types and cell operation codes for the top-k sorted list.
package tksi_pkg;

  // Default build sizes.
  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned KEY_BITS_DEF    = 48;
  localparam int unsigned TAG_BITS_DEF    = 32;

  // Fixed field widths of the ports.
  localparam int unsigned CFG_BITS  = 7;
  localparam int unsigned SLOT_BITS = 6;

  // Value of the entries_in_use register after reset.
  localparam logic [CFG_BITS-1:0] ENTRIES_RESET = 7'd64;

  // Input command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  // What one cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_e;

endpackage

### hw/rtl/tksi_if.sv
// Valid/ready channel interfaces for the request and result streams.
interface tksi_in_if #(
  parameter int unsigned KEY_BITS = tksi_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS = tksi_pkg::TAG_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                command;
  logic [KEY_BITS-1:0] item_key;
  logic [TAG_BITS-1:0] item_tag;

  modport source (output valid, command, item_key, item_tag, input ready);
  modport sink   (input valid, command, item_key, item_tag, output ready);
endinterface

interface tksi_out_if #(
  parameter int unsigned KEY_BITS = tksi_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS = tksi_pkg::TAG_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic                           admitted;
  logic [tksi_pkg::SLOT_BITS-1:0] slot;
  logic                           evicted;
  logic [TAG_BITS-1:0]            evicted_tag;
  logic [KEY_BITS-1:0]            entry_key;
  logic [TAG_BITS-1:0]            entry_tag;
  logic                           entry_valid;
  logic                           last;

  modport source (output valid, admitted, slot, evicted, evicted_tag, entry_key,
                  entry_tag, entry_valid, last, input ready);
  modport sink   (input valid, admitted, slot, evicted, evicted_tag, entry_key,
                  entry_tag, entry_valid, last, output ready);
endinterface

### hw/rtl/top_k_sorted_insert.sv
// Top level of the top-k sorted list: control, cell chain and result register.
//
// Requests arrive on req_i (command, item_key, item_tag); results leave on rsp_o.
// Both are valid/ready channels; a transfer happens when valid and ready are high.
// The entries_in_use register is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while idle, the block itself does not enforce it. An insert
// compares the key against every cell of the chain at once and shifts the lower
// ranks down by one in the same cycle, so its single result sits in the output
// register in the cycle after the transfer. Back-to-back inserts run at one per
// cycle while the receiver keeps up. On a dump of n held entries the chain rotates
// one rank per cycle towards rank 0 while the receiver keeps up; rank 0 feeds the
// output register, so after n steps the list is back in its original order. An
// empty dump gives one result. The output register lets a new request in while
// the result is taken in the same cycle; when the receiver stalls, the held
// result and the chain freeze and req_i.ready stays low. Reset (rst_ni low)
// empties the list and sets entries_in_use to 64; no clearing pass is needed.
module top_k_sorted_insert #(
  parameter int unsigned MAX_ENTRIES = tksi_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned KEY_BITS    = tksi_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS    = tksi_pkg::TAG_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tksi_pkg::CFG_BITS-1:0] cfg_wdata_i,
  tksi_in_if.sink                       req_i,
  tksi_out_if.source                    rsp_o
);
  import tksi_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // Clamp a register value to the range 1 .. MAX_ENTRIES.
  function automatic logic [CNT_W-1:0] clamp_k(input logic [CFG_BITS-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CFG_BITS'(MAX_ENTRIES)) begin
      r = CNT_W'(MAX_ENTRIES);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  logic [CFG_BITS-1:0] cfg_q, cfg_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                busy_q, busy_d;
  logic [IDX_W-1:0]    dump_idx_q, dump_idx_d;

  logic                out_vld_q, out_vld_d;
  logic                out_adm_q, out_adm_d;
  logic [SLOT_BITS-1:0] out_slot_q, out_slot_d;
  logic                out_ev_q, out_ev_d;
  logic [TAG_BITS-1:0] out_evtag_q, out_evtag_d;
  logic [KEY_BITS-1:0] out_ekey_q, out_ekey_d;
  logic [TAG_BITS-1:0] out_etag_q, out_etag_d;
  logic                out_evld_q, out_evld_d;
  logic                out_last_q, out_last_d;

  logic [KEY_BITS-1:0] cell_key [MAX_ENTRIES];
  logic [TAG_BITS-1:0] cell_tag [MAX_ENTRIES];
  logic [KEY_BITS-1:0] rot_key  [MAX_ENTRIES];
  logic [TAG_BITS-1:0] rot_tag  [MAX_ENTRIES];
  cell_op_e            cell_op  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] below, occ, goes, take, shift;

  logic [CNT_W-1:0] k_eff;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] pos;
  logic             full, admit, out_free, req_fire, ins_fire, dump_step, dump_last;

  // Effective list length and the rank of the smallest kept entry.
  assign k_eff    = clamp_k(cfg_q);
  assign last_idx = IDX_W'(k_eff - CNT_W'(1));
  assign full     = count_q >= k_eff;
  assign admit    = !full || below[last_idx];

  // Handshake: one request at a time, and only with room in the output register.
  assign out_free    = !out_vld_q || rsp_o.ready;
  assign req_i.ready = !busy_q && out_free;
  assign req_fire    = req_i.valid && req_i.ready;
  assign ins_fire    = req_fire && (req_i.command == CMD_INSERT) && admit;
  assign dump_step   = busy_q && out_free;
  assign dump_last   = CNT_W'(dump_idx_q) == (count_q - CNT_W'(1));

  // Per-rank placement: the new item lands on the first rank that is empty or
  // holds a strictly smaller key; every rank after it takes its upper neighbor.
  always_comb begin
    pos = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      occ[i]  = CNT_W'(i) < count_q;
      goes[i] = !occ[i] || below[i];
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (i == 0) begin
        take[i]  = goes[i];
        shift[i] = 1'b0;
      end else begin
        take[i]  = goes[i] && !goes[i-1];
        shift[i] = goes[i-1];
      end
      if (take[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  // Cell operations and the rotation path used by a dump.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if ((i + 1 < MAX_ENTRIES) && (CNT_W'(i + 1) < count_q)) begin
        rot_key[i] = cell_key[(i + 1) % MAX_ENTRIES];
        rot_tag[i] = cell_tag[(i + 1) % MAX_ENTRIES];
      end else begin
        rot_key[i] = cell_key[0];
        rot_tag[i] = cell_tag[0];
      end
      if (ins_fire) begin
        if (take[i]) begin
          cell_op[i] = CELL_LOAD;
        end else if (shift[i]) begin
          cell_op[i] = CELL_SHIFT;
        end else begin
          cell_op[i] = CELL_HOLD;
        end
      end else if (dump_step && occ[i]) begin
        cell_op[i] = CELL_ROTATE;
      end else begin
        cell_op[i] = CELL_HOLD;
      end
    end
  end

  // The chain of ranks.
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    tksi_cell #(
      .KEY_BITS (KEY_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (cell_op[g]),
      .new_key_i (req_i.item_key),
      .new_tag_i (req_i.item_tag),
      .up_key_i  (cell_key[(g + MAX_ENTRIES - 1) % MAX_ENTRIES]),
      .up_tag_i  (cell_tag[(g + MAX_ENTRIES - 1) % MAX_ENTRIES]),
      .rot_key_i (rot_key[g]),
      .rot_tag_i (rot_tag[g]),
      .key_o     (cell_key[g]),
      .tag_o     (cell_tag[g]),
      .below_o   (below[g])
    );
  end

  // Control and result register next state.
  always_comb begin
    cfg_d       = cfg_q;
    count_d     = count_q;
    busy_d      = busy_q;
    dump_idx_d  = dump_idx_q;
    out_vld_d   = out_vld_q && !rsp_o.ready;
    out_adm_d   = out_adm_q;
    out_slot_d  = out_slot_q;
    out_ev_d    = out_ev_q;
    out_evtag_d = out_evtag_q;
    out_ekey_d  = out_ekey_q;
    out_etag_d  = out_etag_q;
    out_evld_d  = out_evld_q;
    out_last_d  = out_last_q;

    if (cfg_we_i) begin
      // A lower limit drops the ranks at and beyond it.
      cfg_d = cfg_wdata_i;
      if (count_q > clamp_k(cfg_wdata_i)) begin
        count_d = clamp_k(cfg_wdata_i);
      end
    end else if (req_fire && (req_i.command == CMD_INSERT)) begin
      out_vld_d   = 1'b1;
      out_adm_d   = admit;
      out_slot_d  = admit ? SLOT_BITS'(pos) : '0;
      out_ev_d    = admit && full;
      out_evtag_d = (admit && full) ? cell_tag[last_idx] : '0;
      out_ekey_d  = '0;
      out_etag_d  = '0;
      out_evld_d  = 1'b0;
      out_last_d  = 1'b1;
      if (admit && !full) begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (req_fire) begin
      if (count_q == '0) begin
        // Empty list: a single marker result.
        out_vld_d   = 1'b1;
        out_adm_d   = 1'b0;
        out_slot_d  = '0;
        out_ev_d    = 1'b0;
        out_evtag_d = '0;
        out_ekey_d  = '0;
        out_etag_d  = '0;
        out_evld_d  = 1'b0;
        out_last_d  = 1'b1;
      end else begin
        busy_d     = 1'b1;
        dump_idx_d = '0;
      end
    end else if (dump_step) begin
      // Rank 0 goes out while the chain rotates one place.
      out_vld_d   = 1'b1;
      out_adm_d   = 1'b0;
      out_slot_d  = SLOT_BITS'(dump_idx_q);
      out_ev_d    = 1'b0;
      out_evtag_d = '0;
      out_ekey_d  = cell_key[0];
      out_etag_d  = cell_tag[0];
      out_evld_d  = 1'b1;
      out_last_d  = dump_last;
      dump_idx_d  = dump_idx_q + IDX_W'(1);
      if (dump_last) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= ENTRIES_RESET;
      count_q    <= '0;
      busy_q     <= 1'b0;
      dump_idx_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      cfg_q      <= cfg_d;
      count_q    <= count_d;
      busy_q     <= busy_d;
      dump_idx_q <= dump_idx_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    out_adm_q   <= out_adm_d;
    out_slot_q  <= out_slot_d;
    out_ev_q    <= out_ev_d;
    out_evtag_q <= out_evtag_d;
    out_ekey_q  <= out_ekey_d;
    out_etag_q  <= out_etag_d;
    out_evld_q  <= out_evld_d;
    out_last_q  <= out_last_d;
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.admitted    = out_adm_q;
  assign rsp_o.slot        = out_slot_q;
  assign rsp_o.evicted     = out_ev_q;
  assign rsp_o.evicted_tag = out_evtag_q;
  assign rsp_o.entry_key   = out_ekey_q;
  assign rsp_o.entry_tag   = out_etag_q;
  assign rsp_o.entry_valid = out_evld_q;
  assign rsp_o.last        = out_last_q;

`ifndef NO_ASSERTIONS
  // The held count never exceeds the configured list length.
  a_count_le_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= k_eff)
    else $error("held count exceeds list length");

  // An insert never lands on more than one rank.
  a_take_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_fire |-> $onehot(take))
    else $error("insert placed on several ranks");

  // An eviction is only reported for an admitted item.
  a_evict_admit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_ev_q) |-> out_adm_q)
    else $error("eviction without admission");

  // The list size stays unchanged during a dump unless the register is written.
  a_dump_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !cfg_we_i) |=> $stable(count_q))
    else $error("list size changed during dump");
`endif

endmodule

### hw/rtl/tksi_cell.sv
// One rank of the sorted list: holds a key and tag and compares against the new key.
module tksi_cell #(
  parameter int unsigned KEY_BITS = tksi_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS = tksi_pkg::TAG_BITS_DEF
) (
  input  logic                    clk_i,
  input  tksi_pkg::cell_op_e      op_i,
  input  logic [KEY_BITS-1:0]     new_key_i,
  input  logic [TAG_BITS-1:0]     new_tag_i,
  input  logic [KEY_BITS-1:0]     up_key_i,
  input  logic [TAG_BITS-1:0]     up_tag_i,
  input  logic [KEY_BITS-1:0]     rot_key_i,
  input  logic [TAG_BITS-1:0]     rot_tag_i,
  output logic [KEY_BITS-1:0]     key_o,
  output logic [TAG_BITS-1:0]     tag_o,
  output logic                    below_o
);
  import tksi_pkg::*;

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;

  // The held key ranks below the incoming one only when strictly smaller.
  assign below_o = key_q < new_key_i;

  // Select the source of this rank for the next cycle.
  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    case (op_i)
      CELL_HOLD: begin
        key_d = key_q;
        tag_d = tag_q;
      end
      CELL_LOAD: begin
        key_d = new_key_i;
        tag_d = new_tag_i;
      end
      CELL_SHIFT: begin
        key_d = up_key_i;
        tag_d = up_tag_i;
      end
      CELL_ROTATE: begin
        key_d = rot_key_i;
        tag_d = rot_tag_i;
      end
      default: begin
        key_d = key_q;
        tag_d = tag_q;
      end
    endcase
  end

  // Entry storage; its contents only count where the rank is occupied.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

### tb/tksi_list_checker.sv
// Checker for the top-k sorted list: tracks the list, predicts every result and compares.
module tksi_list_checker #(
  parameter int unsigned MAX_ENTRIES = tksi_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned KEY_BITS    = tksi_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS    = tksi_pkg::TAG_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tksi_pkg::CFG_BITS-1:0] cfg_wdata_i,
  tksi_in_if                            req_mon,
  tksi_out_if                           rsp_mon,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tksi_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  // One result transfer as the block presents it.
  typedef struct packed {
    logic                 admitted;
    logic [SLOT_BITS-1:0] slot;
    logic                 evicted;
    logic [TAG_BITS-1:0]  evicted_tag;
    logic [KEY_BITS-1:0]  entry_key;
    logic [TAG_BITS-1:0]  entry_tag;
    logic                 entry_valid;
    logic                 last;
  } list_result_t;

  // Shadow copy of the ranked list, highest key at rank 0.
  logic [KEY_BITS-1:0] rank_key [MAX_ENTRIES];
  logic [TAG_BITS-1:0] rank_tag [MAX_ENTRIES];
  int unsigned         held_entries;
  int unsigned         keep_limit;

  list_result_t results_due [$];
  int unsigned  mismatches = 0;
  int unsigned  waiting    = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  // Out-of-range register values saturate to the legal range of k.
  function automatic int unsigned clamp_limit(input logic [CFG_BITS-1:0] value);
    if (value == '0) begin
      return 1;
    end
    if (int'(value) > int'(MAX_ENTRIES)) begin
      return MAX_ENTRIES;
    end
    return int'(value);
  endfunction

  function automatic string show_result(input list_result_t r);
    return $sformatf("adm=%0b slot=%0d ev=%0b ev_tag=%h key=%h tag=%h vld=%0b last=%0b",
                     r.admitted, r.slot, r.evicted, r.evicted_tag, r.entry_key,
                     r.entry_tag, r.entry_valid, r.last);
  endfunction

  // Works out the results of one accepted request and updates the shadow list.
  task automatic predict_list_op(input logic cmd, input logic [KEY_BITS-1:0] key,
                                 input logic [TAG_BITS-1:0] tag);
    list_result_t r;
    int unsigned  pos;
    int unsigned  i;
    r      = '0;
    r.last = 1'b1;
    if (cmd == CMD_DUMP) begin
      // An empty list still answers with a single invalid entry.
      if (held_entries == 0) begin
        results_due.push_back(r);
        return;
      end
      for (i = 0; i < held_entries; i++) begin
        r             = '0;
        r.slot        = SLOT_BITS'(i);
        r.entry_key   = rank_key[i];
        r.entry_tag   = rank_tag[i];
        r.entry_valid = 1'b1;
        r.last        = (i + 1 == held_entries);
        results_due.push_back(r);
      end
      return;
    end
    // A full list only takes a key strictly above its smallest one.
    if (held_entries >= keep_limit && !(rank_key[keep_limit-1] < key)) begin
      results_due.push_back(r);
      return;
    end
    if (held_entries >= keep_limit) begin
      r.evicted     = 1'b1;
      r.evicted_tag = rank_tag[keep_limit-1];
      held_entries  = keep_limit - 1;
    end
    // Equal keys keep their place ahead of the newcomer.
    pos = 0;
    while (pos < held_entries && !(rank_key[pos] < key)) begin
      pos++;
    end
    for (i = held_entries; i > pos; i--) begin
      rank_key[i] = rank_key[i-1];
      rank_tag[i] = rank_tag[i-1];
    end
    rank_key[pos] = key;
    rank_tag[pos] = tag;
    held_entries++;
    r.admitted = 1'b1;
    r.slot     = SLOT_BITS'(pos);
    results_due.push_back(r);
  endtask

  // Compares one accepted result against the oldest expectation.
  task automatic check_list_result();
    list_result_t got;
    list_result_t want;
    got.admitted    = rsp_mon.admitted;
    got.slot        = rsp_mon.slot;
    got.evicted     = rsp_mon.evicted;
    got.evicted_tag = rsp_mon.evicted_tag;
    got.entry_key   = rsp_mon.entry_key;
    got.entry_tag   = rsp_mon.entry_tag;
    got.entry_valid = rsp_mon.entry_valid;
    got.last        = rsp_mon.last;
    if (results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%0t: unexpected result: %s", $realtime, show_result(got));
      end
      return;
    end
    want = results_due.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%0t: result mismatch", $realtime);
        $display("  expected %s", show_result(want));
        $display("  actual   %s", show_result(got));
      end
    end
  endtask

  // Register writes, result checks and request predictions, all on the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_entries = 0;
      keep_limit   = clamp_limit(ENTRIES_RESET);
      results_due.delete();
      waiting      = 0;
    end else begin
      if (cfg_we_i) begin
        keep_limit = clamp_limit(cfg_wdata_i);
        if (held_entries > keep_limit) begin
          held_entries = keep_limit;
        end
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        check_list_result();
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_list_op(req_mon.command, req_mon.item_key, req_mon.item_tag);
      end
      waiting = results_due.size();
    end
  end

endmodule

### tb/tb_top_k_sorted_insert.sv
// Testbench top for the top-k sorted list: clock, reset, stimulus, back-pressure and verdict.
module tb_top_k_sorted_insert;
  timeunit 1ns;
  timeprecision 1ps;

  import tksi_pkg::*;

  localparam int unsigned KEY_BITS     = KEY_BITS_DEF;
  localparam int unsigned TAG_BITS     = TAG_BITS_DEF;
  localparam int unsigned HALF_PERIOD  = 10;
  localparam int unsigned RESET_CYCLES = 3;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned DRAIN        = 20;

  localparam logic [KEY_BITS-1:0] KEY_ONE = KEY_BITS'(48'h1_0000);
  localparam logic [KEY_BITS-1:0] KEY_TOP = '1;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         idle_cycles = 0;
  int unsigned         send_burst  = 0;
  bit                  hold_rsp    = 1'b0;

  tksi_in_if  #(.KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)) req_ch ();
  tksi_out_if #(.KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)) rsp_ch ();

  top_k_sorted_insert i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  tksi_list_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Idle stretch length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 30);
  endfunction

  // Keys: full-range values, a small set of whole numbers for ties, and both extremes.
  function automatic logic [KEY_BITS-1:0] pick_key();
    logic [63:0] wide;
    int unsigned sel;
    wide = {$urandom, $urandom};
    sel  = $urandom_range(0, 9);
    if (sel < 4) begin
      return wide[KEY_BITS-1:0];
    end
    if (sel < 8) begin
      return KEY_BITS'($urandom_range(0, 12)) << 16;
    end
    if (sel == 8) begin
      return KEY_TOP - KEY_BITS'($urandom_range(0, 3));
    end
    return KEY_BITS'($urandom_range(0, 3));
  endfunction

  // Offers one request after a random gap and returns at the falling edge after its transfer.
  task automatic send_req(input logic cmd, input logic [KEY_BITS-1:0] key,
                          input logic [TAG_BITS-1:0] tag);
    int unsigned gap;
    if (send_burst == 0 && $urandom_range(0, 15) == 0) begin
      send_burst = $urandom_range(5, 20);
    end
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.command  <= cmd;
    req_ch.item_key <= key;
    req_ch.item_tag <= tag;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Writes the k register once the list has answered everything sent so far.
  task automatic write_entries(input logic [CFG_BITS-1:0] value);
    req_ch.valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random phase at a given k; dumps come roughly once in dump_odds requests.
  task automatic run_phase(input logic [CFG_BITS-1:0] k_value, input int unsigned count,
                           input int unsigned dump_odds, input bit with_hold);
    int unsigned n;
    logic        cmd;
    write_entries(k_value);
    for (n = 0; n < count; n++) begin
      if (with_hold && n == 12) begin
        hold_rsp = 1'b1;
      end
      cmd = ($urandom_range(1, dump_odds) == 1) ? CMD_DUMP : CMD_INSERT;
      send_req(cmd, pick_key(), $urandom);
    end
  endtask

  // Receiver: runs of steady acceptance alternate with runs of random stalls.
  initial begin
    int unsigned run_left;
    int unsigned stall_left;
    int unsigned mode;
    run_left   = 0;
    stall_left = 0;
    mode       = 0;
    rsp_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        // Long hold-off so the output register fills and the input stalls.
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 2);
          run_left = $urandom_range(8, 60);
        end
        run_left--;
        if (stall_left > 0) begin
          stall_left--;
          rsp_ch.ready <= 1'b0;
        end else if (mode != 0 && $urandom_range(0, 99) < 15 * mode) begin
          stall_left   = pick_gap();
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer on either channel.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    req_ch.valid    = 1'b0;
    req_ch.command  = CMD_INSERT;
    req_ch.item_key = '0;
    req_ch.item_tag = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty dump, key extremes, ties placed after equal keys.
    send_req(CMD_DUMP,   '0,      '0);
    send_req(CMD_INSERT, '0,      '0);
    send_req(CMD_INSERT, KEY_TOP, '1);
    send_req(CMD_INSERT, KEY_ONE, 32'd1);
    send_req(CMD_INSERT, KEY_ONE, 32'd2);
    send_req(CMD_INSERT, '0,      32'd3);
    send_req(CMD_DUMP,   KEY_TOP, '1);

    // Lowering k below the held count drops the tail; equal keys are not admitted.
    write_entries(CFG_BITS'(2));
    send_req(CMD_DUMP,   '0,           '0);
    send_req(CMD_INSERT, KEY_ONE,      32'd4);
    send_req(CMD_INSERT, KEY_ONE << 1, 32'd5);
    send_req(CMD_INSERT, '0,           32'd6);
    send_req(CMD_DUMP,   '0,           '0);

    // A zero register acts as one, an oversized one as the full capacity.
    write_entries('0);
    send_req(CMD_INSERT, KEY_TOP, 32'd7);
    send_req(CMD_INSERT, '0,      32'd8);
    send_req(CMD_DUMP,   '0,      '0);
    write_entries('1);
    send_req(CMD_INSERT, KEY_TOP, 32'hA5A5_5A5A);
    send_req(CMD_DUMP,   '0,      '0);

    // Random phases over several k settings; the first one fills the whole list.
    run_phase(CFG_BITS'(64),  75, 16, 1'b1);
    run_phase(CFG_BITS'(6),   20, 6,  1'b0);
    run_phase('0,             15, 5,  1'b0);
    run_phase('1,             25, 8,  1'b0);
    run_phase(CFG_BITS'(3),   20, 6,  1'b0);
    run_phase(CFG_BITS'(40),  25, 7,  1'b0);

    req_ch.valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
